// File: rtl/core/svg_pkg.sv
// Package for the sphere vertex generator: stage counts, fixed-point constants,
// sideband types and small arithmetic helpers.
// No dependencies.
package svg_pkg;

	// angle divider: one quotient bit per stage
	localparam int DIV_BITS = 16;
	localparam int NUM_W    = 25;
	localparam int DEN_W    = 9;

	// quarter-wave sine pipeline
	localparam int HSTEPS = 7;
	localparam int QS_LAT = 2 + 3 * HSTEPS + 2;

	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [14:0] QUARTER     = 15'd16384;

	// Horner steps for k = 14 down to 2: divide by k*(k+1) as a reciprocal
	// multiply floor(2^s / D) followed by one correction
	localparam logic [7:0] HORNER_DIV [HSTEPS] = '{
		8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
	};
	localparam logic [31:0] HORNER_MUL [HSTEPS] = '{
		32'd2617884828, 32'd3524075730, 32'd2498890063, 32'd3817748707,
		32'd3272356035, 32'd3435973836, 32'd2863311530
	};
	localparam int HORNER_SHIFT [HSTEPS] = '{39, 39, 38, 38, 37, 36, 34};

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_LEVELS = 2'd1,
		REG_POINTS = 2'd2
	} cfg_reg_t;

	typedef logic signed [16:0] trig_t;

	typedef struct packed {
		logic err;
		logic lneg;
		logic lzero;
		logic sa_neg;
		logic ca_neg;
		logic sb_neg;
		logic cb_neg;
	} side_t;

	// fold a turn fraction onto the first quadrant, 0..16384
	function automatic logic [14:0] quad_fold(input logic [15:0] a);
		return a[14] ? 15'(QUARTER - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
	endfunction

	function automatic trig_t trig_val(input logic [15:0] m, input logic neg);
		trig_t v;
		v = $signed({1'b0, m});
		return neg ? trig_t'(-v) : v;
	endfunction

	// v / 32768 rounded to nearest, ties away from zero
	function automatic logic signed [17:0] round_q15(input logic signed [35:0] v);
		logic [35:0]        mag;
		logic [20:0]        r;
		logic signed [17:0] rs;
		mag = v[35] ? 36'(-v) : 36'(v);
		r   = 21'((mag + 36'd16384) >> 15);
		rs  = $signed({1'b0, r[16:0]});
		return v[35] ? 18'(-rs) : rs;
	endfunction

endpackage

// File: rtl/core/svg_angdiv.sv
// Pipelined restoring divider for the level and point angles, two lanes.
// Depends on svg_pkg.
module svg_angdiv import svg_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [NUM_W-1:0]     nl,
	input  logic [DEN_W-1:0]     dl,
	input  logic [NUM_W-1:0]     np,
	input  logic [DEN_W-1:0]     dp,
	output logic [DIV_BITS-1:0]  ql,
	output logic [DIV_BITS-1:0]  qp
);

	logic [NUM_W-1:0]    rl_s [DIV_BITS];
	logic [NUM_W-1:0]    rp_s [DIV_BITS];
	logic [DIV_BITS-1:0] ql_s [DIV_BITS];
	logic [DIV_BITS-1:0] qp_s [DIV_BITS];
	logic [DEN_W-1:0]    dl_s [DIV_BITS];
	logic [DEN_W-1:0]    dp_s [DIV_BITS];

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_bit
		localparam int B = DIV_BITS - 1 - i;
		logic [NUM_W-1:0]    rl_in, rp_in, subl, subp;
		logic [DIV_BITS-1:0] ql_in, qp_in;
		logic [DEN_W-1:0]    dl_in, dp_in;
		logic                gel, gep;

		if (i == 0) begin : g_first
			assign rl_in = nl;
			assign rp_in = np;
			assign ql_in = '0;
			assign qp_in = '0;
			assign dl_in = dl;
			assign dp_in = dp;
		end else begin : g_next
			assign rl_in = rl_s[i-1];
			assign rp_in = rp_s[i-1];
			assign ql_in = ql_s[i-1];
			assign qp_in = qp_s[i-1];
			assign dl_in = dl_s[i-1];
			assign dp_in = dp_s[i-1];
		end

		assign subl = NUM_W'(dl_in) << B;
		assign subp = NUM_W'(dp_in) << B;
		assign gel  = rl_in >= subl;
		assign gep  = rp_in >= subp;

		always_ff @(posedge clk) begin
			if (en) begin
				rl_s[i] <= gel ? rl_in - subl : rl_in;
				rp_s[i] <= gep ? rp_in - subp : rp_in;
				ql_s[i] <= ql_in | (DIV_BITS'(gel) << B);
				qp_s[i] <= qp_in | (DIV_BITS'(gep) << B);
				dl_s[i] <= dl_in;
				dp_s[i] <= dp_in;
			end
		end
	end

	assign ql = ql_s[DIV_BITS-1];
	assign qp = qp_s[DIV_BITS-1];

endmodule

// File: rtl/core/svg_qsine.sv
// Pipelined quarter-wave sine: Q30 Taylor series in Horner form, rounded to Q15.
// Depends on svg_pkg.
module svg_qsine import svg_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [14:0] f,
	output logic [15:0] m
);

	logic [30:0] t_s1, t_s2;
	logic [31:0] t2_s2;
	logic [45:0] targ;
	logic [61:0] tsq;

	logic [30:0] ta_s  [HSTEPS];
	logic [31:0] t2a_s [HSTEPS];
	logic [31:0] xa_s  [HSTEPS];
	logic [30:0] tb_s  [HSTEPS];
	logic [31:0] t2b_s [HSTEPS];
	logic [31:0] xb_s  [HSTEPS];
	logic [31:0] q0b_s [HSTEPS];
	logic [30:0] tc_s  [HSTEPS];
	logic [31:0] t2c_s [HSTEPS];
	logic [30:0] p_s   [HSTEPS];

	logic [61:0] fin_prod;
	logic [30:0] s_s24;
	logic [31:0] rsum;
	logic [16:0] rnd;
	logic [15:0] m_s25;

	assign targ = 46'(f) * 46'(HALF_PI_Q30);
	assign tsq  = 62'(t_s1) * 62'(t_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= targ[44:14];
			t_s2  <= t_s1;
			t2_s2 <= tsq[61:30];
		end
	end

	for (genvar j = 0; j < HSTEPS; j++) begin : g_step
		logic [30:0] p_in, t_in;
		logic [31:0] t2_in;
		logic [62:0] prod_a;
		logic [63:0] prod_b;
		logic [39:0] qd, rem;
		logic [31:0] q;

		if (j == 0) begin : g_first
			assign p_in  = Q30_ONE;
			assign t_in  = t_s2;
			assign t2_in = t2_s2;
		end else begin : g_next
			assign p_in  = p_s[j-1];
			assign t_in  = tc_s[j-1];
			assign t2_in = t2c_s[j-1];
		end

		assign prod_a = 63'(t2_in) * 63'(p_in);
		assign prod_b = 64'(xa_s[j]) * 64'(HORNER_MUL[j]);
		assign qd     = 40'(q0b_s[j]) * 40'(HORNER_DIV[j]);
		assign rem    = 40'(xb_s[j]) - qd;
		// reciprocal estimate is low by at most one
		assign q      = q0b_s[j] + 32'(rem >= 40'(HORNER_DIV[j]));

		always_ff @(posedge clk) begin
			if (en) begin
				ta_s[j]  <= t_in;
				t2a_s[j] <= t2_in;
				xa_s[j]  <= prod_a[61:30];
				tb_s[j]  <= ta_s[j];
				t2b_s[j] <= t2a_s[j];
				xb_s[j]  <= xa_s[j];
				q0b_s[j] <= 32'(prod_b >> HORNER_SHIFT[j]);
				tc_s[j]  <= tb_s[j];
				t2c_s[j] <= t2b_s[j];
				p_s[j]   <= 31'(Q30_ONE - 31'(q));
			end
		end
	end

	assign fin_prod = 62'(tc_s[HSTEPS-1]) * 62'(p_s[HSTEPS-1]);
	assign rsum     = 32'(s_s24) + 32'd16384;
	assign rnd      = rsum[31:15];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s24 <= fin_prod[60:30];
			m_s25 <= (rnd > 17'd32768) ? 16'd32768 : rnd[15:0];
		end
	end

	assign m = m_s25;

endmodule

// File: rtl/core/sphere_vertex_generator_unit.sv
// Sphere vertex generator: one vertex of a latitude/longitude sphere per query.
// Depends on svg_pkg, svg_angdiv and svg_qsine.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one query item: a signed
//   level_index and a point_index. Output channel (out_valid / out_stall)
//   returns one result item per query: x_coord, y_coord, z_coord in signed
//   Q8.8 and index_error, which is set with zero coordinates when the query
//   lies outside the configured level or point count.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes radius,
//   level_count and points_per_level; cfg_ready is always high. Write only
//   while no item is in flight.
// Timing:
//   46 register stages: one input stage, 16 divider stages (one quotient bit
//   each), 25 sine stages (seven Horner steps of multiply, reciprocal
//   multiply and correct) and four product and rounding stages. One item
//   enters per cycle while out_stall does not hold the pipeline.
// Reset:
//   arst_n clears all stage valid bits and loads radius 256, 8 levels and
//   16 points. Items in flight are dropped.
// Stall:
//   While a result waits on out_stall the whole pipeline holds, bubbles
//   included, and in_stall is raised for exactly those cycles.
module sphere_vertex_generator_unit import svg_pkg::*; #(
	parameter int MAX_LEVELS = 64,
	parameter int MAX_POINTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [7:0]  level_index,
	input  logic [7:0]         point_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] x_coord,
	output logic signed [16:0] y_coord,
	output logic signed [16:0] z_coord,
	output logic               index_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	// configuration registers
	logic [15:0] radius_q;
	logic [6:0]  level_count_q;
	logic [8:0]  points_q;

	logic en;

	// stage valid bits
	logic vld_s1;
	logic vld_d [DIV_BITS];
	logic vld_t [QS_LAT];
	logic vld_p [4];

	// input stage
	logic signed [7:0] lvl_s1;
	logic [7:0]        pt_s1;

	logic [7:0]       mag;
	logic [6:0]       lc;
	logic [8:0]       pc;
	logic [NUM_W-1:0] nl, np;
	side_t            side_in;

	side_t sb_d [DIV_BITS];
	side_t sb_t [QS_LAT];

	logic [DIV_BITS-1:0] ql, qp;
	logic [15:0]         la, la_c, pa_c;
	side_t               side_ang;
	logic [15:0]         m_sa, m_ca, m_sb, m_cb;
	trig_t               sa, ca, sb, cb;

	// product and rounding stages
	logic signed [33:0] ringp_p0, zp_p0;
	trig_t              cosb_p0, sinb_p0, cosb_p1, sinb_p1;
	logic               err_p0, err_p1, err_p2, lneg_p0;
	logic signed [17:0] ring_p1, z_p1, z_p2, zr;
	logic signed [35:0] xp_p2, yp_p2;
	logic signed [16:0] x_p3, y_p3, z_p3;
	logic               err_p3;

	logic signed [16:0] rad_s;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= 16'd256;
			level_count_q <= 7'd8;
			points_q      <= 9'd16;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RADIUS: radius_q      <= cfg_data;
				REG_LEVELS: level_count_q <= cfg_data[6:0];
				REG_POINTS: points_q      <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// hold everything while the output item is refused
	assign en       = !(vld_p[3] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i < DIV_BITS; i++) vld_d[i] <= 1'b0;
			for (int i = 0; i < QS_LAT; i++) vld_t[i] <= 1'b0;
			for (int i = 0; i < 4; i++) vld_p[i] <= 1'b0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_d[0] <= vld_s1;
			for (int i = 1; i < DIV_BITS; i++) vld_d[i] <= vld_d[i-1];
			vld_t[0] <= vld_d[DIV_BITS-1];
			for (int i = 1; i < QS_LAT; i++) vld_t[i] <= vld_t[i-1];
			vld_p[0] <= vld_t[QS_LAT-1];
			for (int i = 1; i < 4; i++) vld_p[i] <= vld_p[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lvl_s1 <= level_index;
			pt_s1  <= point_index;
		end
	end

	// clamp counts to the build limits, check range, form rounded numerators
	assign lc  = (32'(level_count_q) > MAX_LEVELS) ? 7'(MAX_LEVELS) : level_count_q;
	assign pc  = (32'(points_q) > MAX_POINTS) ? 9'(MAX_POINTS) : points_q;
	assign mag = lvl_s1[7] ? 8'(-lvl_s1) : 8'(lvl_s1);
	assign nl  = (NUM_W'(mag[6:0]) << 14) + NUM_W'(lc >> 1);
	assign np  = (NUM_W'(pt_s1) << 16) + NUM_W'(pc >> 1);

	always_comb begin
		side_in        = '0;
		side_in.err    = (mag > {1'b0, lc}) || ({1'b0, pt_s1} >= pc);
		side_in.lneg   = lvl_s1[7];
		side_in.lzero  = (mag == 8'd0);
	end

	svg_angdiv u_div (
		.clk (clk),
		.en  (en),
		.nl  (nl),
		.dl  (DEN_W'(lc)),
		.np  (np),
		.dp  (pc),
		.ql  (ql),
		.qp  (qp)
	);

	// equator takes angle zero even with a zero level count
	assign la   = sb_d[DIV_BITS-1].lzero ? 16'd0 : ql;
	assign la_c = la + 16'(QUARTER);
	assign pa_c = qp + 16'(QUARTER);

	always_comb begin
		side_ang        = sb_d[DIV_BITS-1];
		side_ang.sa_neg = la[15];
		side_ang.ca_neg = la_c[15];
		side_ang.sb_neg = qp[15];
		side_ang.cb_neg = pa_c[15];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_d[0] <= side_in;
			for (int i = 1; i < DIV_BITS; i++) sb_d[i] <= sb_d[i-1];
			sb_t[0] <= side_ang;
			for (int i = 1; i < QS_LAT; i++) sb_t[i] <= sb_t[i-1];
		end
	end

	svg_qsine u_sin_a (.clk(clk), .en(en), .f(quad_fold(la)),   .m(m_sa));
	svg_qsine u_cos_a (.clk(clk), .en(en), .f(quad_fold(la_c)), .m(m_ca));
	svg_qsine u_sin_b (.clk(clk), .en(en), .f(quad_fold(qp)),   .m(m_sb));
	svg_qsine u_cos_b (.clk(clk), .en(en), .f(quad_fold(pa_c)), .m(m_cb));

	assign sa = trig_val(m_sa, sb_t[QS_LAT-1].sa_neg);
	assign ca = trig_val(m_ca, sb_t[QS_LAT-1].ca_neg);
	assign sb = trig_val(m_sb, sb_t[QS_LAT-1].sb_neg);
	assign cb = trig_val(m_cb, sb_t[QS_LAT-1].cb_neg);

	assign rad_s = $signed({1'b0, radius_q});
	assign zr    = round_q15(36'(zp_p0));

	always_ff @(posedge clk) begin
		if (en) begin
			// ring radius and height
			ringp_p0 <= rad_s * ca;
			zp_p0    <= rad_s * sa;
			cosb_p0  <= cb;
			sinb_p0  <= sb;
			err_p0   <= sb_t[QS_LAT-1].err;
			lneg_p0  <= sb_t[QS_LAT-1].lneg;

			ring_p1  <= round_q15(36'(ringp_p0));
			z_p1     <= lneg_p0 ? 18'(-zr) : zr;
			cosb_p1  <= cosb_p0;
			sinb_p1  <= sinb_p0;
			err_p1   <= err_p0;

			// project the ring onto x and y
			xp_p2    <= ring_p1 * cosb_p1;
			yp_p2    <= ring_p1 * sinb_p1;
			z_p2     <= z_p1;
			err_p2   <= err_p1;

			x_p3     <= err_p2 ? 17'sd0 : 17'(round_q15(xp_p2));
			y_p3     <= err_p2 ? 17'sd0 : 17'(round_q15(yp_p2));
			z_p3     <= err_p2 ? 17'sd0 : 17'(z_p2);
			err_p3   <= err_p2;
		end
	end

	assign out_valid   = vld_p[3];
	assign x_coord     = x_p3;
	assign y_coord     = y_p3;
	assign z_coord     = z_p3;
	assign index_error = err_p3;

	// out-of-range queries give a zero vertex
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> x_coord == 17'sd0 && y_coord == 17'sd0
			&& z_coord == 17'sd0)
		else $error("error item with nonzero vertex");

	// input backs up only behind a refused output item
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// an in-range level angle never exceeds a quarter turn
	a_level_angle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_d[DIV_BITS-1] && !sb_d[DIV_BITS-1].err |-> la <= 16'd16384)
		else $error("level angle beyond quarter turn");

	// a held item survives the stall: x_coord and z_coord stay stable
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(x_coord) && $stable(z_coord))
		else $error("output item changed while stalled");

endmodule

// File: test/sphere_vertex_generator_unit_test.sv
// Testbench for sphere_vertex_generator_unit: self-checking, with its own vertex predictor.
// Depends on svg_pkg and the sphere vertex generator RTL.
module sphere_vertex_generator_unit_test import svg_pkg::*; ();

	localparam int PIPE_LAT   = 46;
	localparam int IDLE_LIMIT = 4000;
	localparam int NUM_PHASES = 7;

	typedef struct {
		logic signed [7:0] level;
		logic [7:0]        point;
	} query_t;

	typedef struct {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic signed [16:0] z;
		logic               err;
	} vertex_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [7:0]  level_index;
	logic [7:0]         point_index;
	logic               out_valid;
	logic               out_stall;
	logic signed [16:0] x_coord;
	logic signed [16:0] y_coord;
	logic signed [16:0] z_coord;
	logic               index_error;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	sphere_vertex_generator_unit u_dut (.*);

	// mirror of the configuration registers
	logic [15:0] sph_radius;
	logic [6:0]  sph_levels;
	logic [8:0]  sph_points;

	query_t  query_q[$];
	vertex_t vertex_q[$];
	int      fail_count;
	int      idle_cycles;
	int      gap_left;
	int      burst_left;
	int      stall_mode;
	int      stall_left;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// sine of f/16384 of a quarter turn in Q15, Taylor series in Q30
	function automatic longint unsigned quarter_wave(input longint unsigned f);
		longint unsigned t, t2, p, s, r;
		t  = (f * 64'd1686629713) >> 14;
		t2 = (t * t) >> 30;
		p  = 64'd1 << 30;
		for (int k = 14; k >= 2; k -= 2)
			p = (64'd1 << 30) - ((t2 * p) >> 30) / longint'(k * (k + 1));
		s = (t * p) >> 30;
		r = (s + 64'd16384) >> 15;
		return (r > 64'd32768) ? 64'd32768 : r;
	endfunction

	function automatic longint turn_sin(input logic [15:0] a);
		longint unsigned m;
		m = a[14] ? quarter_wave(64'd16384 - a[13:0]) : quarter_wave(a[13:0]);
		return a[15] ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint turn_cos(input logic [15:0] a);
		return turn_sin(16'(a + 16'd16384));
	endfunction

	// a*b/32768, nearest, ties away from zero
	function automatic longint scale_q15(input longint a, input longint b);
		longint p, m;
		p = a * b;
		m = ((p < 0 ? -p : p) + 64'sd16384) >>> 15;
		return p < 0 ? -m : m;
	endfunction

	function automatic vertex_t predict_vertex(input query_t q);
		vertex_t v;
		int          mag, lc, pc;
		logic [15:0] la, pa;
		longint      ring, z;
		mag = (q.level < 0) ? -int'(q.level) : int'(q.level);
		lc  = (sph_levels > 64) ? 64 : int'(sph_levels);
		pc  = (sph_points > 256) ? 256 : int'(sph_points);
		v = '{x: '0, y: '0, z: '0, err: 1'b1};
		if (mag > lc || int'(q.point) >= pc)
			return v;
		la   = (mag == 0) ? 16'd0 : 16'((mag * 16384 + lc / 2) / lc);
		pa   = 16'((longint'(q.point) * 65536 + pc / 2) / pc);
		ring = scale_q15(longint'(sph_radius), turn_cos(la));
		z    = scale_q15(longint'(sph_radius), turn_sin(la));
		if (q.level < 0)
			z = -z;
		v.x   = 17'(scale_q15(ring, turn_cos(pa)));
		v.y   = 17'(scale_q15(ring, turn_sin(pa)));
		v.z   = 17'(z);
		v.err = 1'b0;
		return v;
	endfunction

	// Driver: bursts of items with random gaps; hold the item while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			level_index <= '0;
			point_index <= '0;
			gap_left    = 0;
			burst_left  = 0;
		end else begin
			automatic logic nxt_valid = in_valid;
			if (in_valid && !in_stall) begin
				vertex_q.push_back(predict_vertex(query_q.pop_front()));
				nxt_valid = 1'b0;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					nxt_valid = 1'b0;
				end else if (query_q.size() > 0) begin
					nxt_valid   = 1'b1;
					level_index <= query_q[0].level;
					point_index <= query_q[0].point;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// pick the next burst and the gap after it
						burst_left = $urandom_range(40);
						gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
					end
				end else begin
					nxt_valid = 1'b0;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// Stall pattern of the receiver: modes of no, light and heavy back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode = 0;
			stall_left = 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(2);
				stall_left = $urandom_range(10, 150);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(3) == 0);
				end
				default: begin
					out_stall <= ($urandom_range(9) < 7);
				end
			endcase
		end
	end

	// Monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (vertex_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d z=%0d err=%0b", $time,
					x_coord, y_coord, z_coord, index_error);
				fail_count++;
			end else begin
				automatic vertex_t e = vertex_q.pop_front();
				if (x_coord !== e.x) begin
					$display("%0t: x_coord expected %0d got %0d", $time, e.x, x_coord);
					fail_count++;
				end
				if (y_coord !== e.y) begin
					$display("%0t: y_coord expected %0d got %0d", $time, e.y, y_coord);
					fail_count++;
				end
				if (z_coord !== e.z) begin
					$display("%0t: z_coord expected %0d got %0d", $time, e.z, z_coord);
					fail_count++;
				end
				if (index_error !== e.err) begin
					$display("%0t: index_error expected %0b got %0b", $time, e.err,
						index_error);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Write one register; call at a rising edge, leaves cfg_valid high.
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RADIUS: sph_radius = data;
			REG_LEVELS: sph_levels = data[6:0];
			REG_POINTS: sph_points = data[8:0];
			default: ;
		endcase
	endtask

	task automatic add_query(input int level, input int point);
		query_t q;
		q.level = 8'(level);
		q.point = 8'(point);
		query_q.push_back(q);
	endtask

	// Mostly in-range queries; some out of range and some wholly random.
	task automatic add_random_query();
		int lc, pc, sel;
		lc  = (sph_levels > 64) ? 64 : int'(sph_levels);
		pc  = (sph_points > 256) ? 256 : int'(sph_points);
		sel = $urandom_range(19);
		if (sel < 15 && pc > 0)
			add_query(int'($urandom_range(2 * lc)) - lc, $urandom_range(pc - 1));
		else if (sel < 17)
			add_query(($urandom_range(1) ? 1 : -1) * (lc + 1 + $urandom_range(3)),
				$urandom_range(255));
		else
			add_query($urandom_range(255), $urandom_range(255));
	endtask

	// Drain: wait for every item to come back, then let the pipeline settle.
	task automatic wait_idle();
		do @(posedge clk); while (query_q.size() > 0 || vertex_q.size() > 0 || in_valid);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	initial begin
		fail_count  = 0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_RADIUS;
		cfg_data    = '0;
		sph_radius  = 16'd256;
		sph_levels  = 7'd8;
		sph_points  = 9'd16;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset counts, equator, poles, field extremes, out of range.
		add_query(0, 0);
		add_query(8, 0);
		add_query(-8, 0);
		add_query(9, 0);
		add_query(-9, 3);
		add_query(0, 15);
		add_query(0, 16);
		add_query(127, 255);
		add_query(-128, 0);
		add_query(-1, 4);
		add_query(4, 12);
		add_query(-4, 8);
		add_query(3, 5);
		add_query(-7, 11);
		add_query(1, 1);
		add_query(0, 255);
		for (int i = 0; i < 100; i++)
			add_random_query();
		wait_idle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_RADIUS, 16'hFFFF);
					write_reg(REG_LEVELS, 16'd64);
					write_reg(REG_POINTS, 16'd256);
				end
				1: begin
					write_reg(REG_RADIUS, 16'd0);
					write_reg(REG_LEVELS, 16'd1);
					write_reg(REG_POINTS, 16'd1);
				end
				2: begin
					// zero counts: equator only, and every point out of range
					write_reg(REG_RADIUS, 16'($urandom));
					write_reg(REG_LEVELS, 16'hFF80);
					write_reg(REG_POINTS, 16'hFE00);
				end
				3: begin
					// counts above the limits get clamped
					write_reg(REG_RADIUS, 16'hFFFF);
					write_reg(REG_LEVELS, 16'h007F);
					write_reg(REG_POINTS, 16'h01FF);
				end
				default: begin
					write_reg(REG_RADIUS, 16'($urandom));
					write_reg(REG_LEVELS, 16'($urandom_range(1, 64)));
					write_reg(REG_POINTS, 16'($urandom_range(1, 256)));
				end
			endcase
			cfg_valid <= 1'b0;
			add_query(0, 0);
			add_query(64, 255);
			add_query(-64, 0);
			add_query(-128, 128);
			for (int i = 0; i < 100; i++)
				add_random_query();
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/svg_pkg.sv
rtl/core/svg_angdiv.sv
rtl/core/svg_qsine.sv
rtl/core/sphere_vertex_generator_unit.sv
test/sphere_vertex_generator_unit_test.sv
